[rtl/core/mpat_pkg.sv]
// Shared constants, types and the byte-wide CRC-32 step for the PAT section parser.
// No dependencies; used by mpat_crc and mpeg2_pat_section_parser.
package mpat_pkg;

   // default sizing
   localparam int MIN_SECTION_BYTES = 12;
   localparam int MAX_SECTION_BYTES = 1024;
   localparam int MAX_PROGRAMS      = 64;

   // section layout
   localparam int HDR_BYTES   = 8;    // fixed header bytes 0..7
   localparam int LOOP_OFFSET = 9;    // length-field bytes not in the program loop
   localparam int ENTRY_BYTES = 4;    // program number + PID
   localparam int CRC_BYTES   = 4;

   localparam int COUNT_W = 7;        // width of program_count on the port

   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_CRC  = 2'd1;
   localparam logic [1:0] STATUS_SIZE = 2'd2;

   // per-beat control from the parser to the CRC unit
   typedef struct packed {
      logic shift;         // byte enters the delay line
      logic run;           // oldest delayed byte goes through the CRC
      logic capture;       // byte belongs to the transmitted CRC word
      logic capture_done;  // byte is the last one of that word
      logic clear;         // end of section, back to reset values
   } crc_ctl_type;

   // last three bytes seen before the current one, newest first
   typedef struct packed {
      logic [7:0] tap0;
      logic [7:0] tap1;
      logic [7:0] tap2;
   } crc_taps_type;

   // MPEG-2 CRC-32, MSB first, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[rtl/core/mpat_crc.sv]
// Four-byte delay line, running CRC-32 and capture of the transmitted CRC word.
// Depends on mpat_pkg.
module mpat_crc (
   input  logic                      clock,
   input  logic                      reset,
   input  mpat_pkg::crc_ctl_type     ctl,
   input  logic [7:0]                data_byte,
   output mpat_pkg::crc_taps_type    taps,
   output logic                      crc_ok
);

   logic [3:0][7:0] dly_ff, dly_in;
   logic [31:0]     crc_ff, crc_in;
   logic [31:0]     rcv_ff, rcv_in;
   logic            rcv_valid_ff, rcv_valid_in;

   always_comb begin
      dly_in       = {dly_ff[2:0], data_byte};
      crc_in       = ctl.run ? mpat_pkg::crc32_byte(crc_ff, dly_ff[3]) : crc_ff;
      rcv_in       = ctl.capture ? {rcv_ff[23:0], data_byte} : rcv_ff;
      rcv_valid_in = rcv_valid_ff | ctl.capture_done;
   end

   // verdict on the state as it stands after this beat
   assign crc_ok    = rcv_valid_in && (rcv_in == crc_in);
   assign taps.tap0 = dly_ff[0];
   assign taps.tap1 = dly_ff[1];
   assign taps.tap2 = dly_ff[2];

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         dly_ff       <= '0;
         crc_ff       <= mpat_pkg::CRC_INIT;
         rcv_ff       <= '0;
         rcv_valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         dly_ff       <= dly_in;
         crc_ff       <= crc_in;
         rcv_ff       <= rcv_in;
         rcv_valid_ff <= rcv_valid_in;
      end
   end

endmodule

[rtl/core/mpeg2_pat_section_parser.sv]
// MPEG-2 program association section parser: top level.
// Depends on mpat_pkg and mpat_crc.
//
// Takes one section byte per beat, first byte first, with req_last_byte on the
// final byte, and takes a beat in every cycle that req_stall is low. Each beat
// is finished in the cycle it is accepted: the header capture, the entry check
// and one byte of CRC-32 sit between the section state and the result register,
// so a result shows on rsp_* the cycle after the beat that caused it. A program entry
// result (rsp_kind 0) follows the fourth byte of each full loop entry, up to
// MaxPrograms; the final byte gives a summary (rsp_kind 1) with the header,
// the entry count and the status, and returns the parser to its start state
// for the next section. Status 1 is a CRC mismatch or a missing CRC word;
// status 2 flags a section shorter than MinSectionBytes or longer than
// MaxSectionBytes, whose entries already sent must be dropped downstream.
// req_stall is high only while a result sits in the output register and
// rsp_stall holds it.

module mpeg2_pat_section_parser #(
   parameter int MinSectionBytes = mpat_pkg::MIN_SECTION_BYTES,
   parameter int MaxSectionBytes = mpat_pkg::MAX_SECTION_BYTES,
   parameter int MaxPrograms     = mpat_pkg::MAX_PROGRAMS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [15:0] rsp_prog_num,
   output logic [12:0] rsp_pmt_pid,
   output logic [7:0]  rsp_tbl_id,
   output logic        rsp_syntax_indicator,
   output logic [15:0] rsp_ts_id,
   output logic [4:0]  rsp_version,
   output logic        rsp_current_next,
   output logic [7:0]  rsp_sect_num,
   output logic [7:0]  rsp_last_sect_num,
   output logic [6:0]  rsp_program_count,
   output logic [1:0]  rsp_status
);

   localparam int POS_W = $clog2(MaxSectionBytes + 1);
   localparam int CNT_W = $clog2(MaxPrograms + 1);
   // compare width: covers byte positions, the length field + 2 and the entry end
   localparam int CMP_W = ((POS_W > 12) ? POS_W : 12) + 2;
   localparam int ENTRY_END = mpat_pkg::HDR_BYTES + mpat_pkg::ENTRY_BYTES * MaxPrograms;

   // ------------------------------------------------------------------
   // section state
   // ------------------------------------------------------------------
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [11:0]      length_ff, length_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       tbl_id_ff, tbl_id_in;
   logic             syntax_ff, syntax_in;
   logic [15:0]      tsid_ff, tsid_in;
   logic [4:0]       version_ff, version_in;
   logic             cur_next_ff, cur_next_in;
   logic [7:0]       sec_num_ff, sec_num_in;
   logic [7:0]       last_sec_ff, last_sec_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff;
   logic [15:0] prog_num_ff;
   logic [12:0] pid_ff;
   logic [7:0]  o_tbl_id_ff;
   logic        o_syntax_ff;
   logic [15:0] o_tsid_ff;
   logic [4:0]  o_version_ff;
   logic        o_cur_next_ff;
   logic [7:0]  o_sec_num_ff;
   logic [7:0]  o_last_sec_ff;
   logic [6:0]  o_count_ff;
   logic [1:0]  o_status_ff;

   logic                   accept;
   logic                   oversize;
   logic                   advance;
   logic [CMP_W-1:0]       pos_x, len_x, crc_start_x, crc_ofs_x, new_pos_x;
   logic                   in_crc_word;
   logic                   entry_hit;
   logic                   size_bad;
   logic [1:0]             status;
   mpat_pkg::crc_ctl_type  crc_ctl;
   mpat_pkg::crc_taps_type crc_taps;
   logic                   crc_ok;

   // output register parts the two sides; input stalls only behind a held result
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // past MaxSectionBytes bytes are dropped until the last one
   assign oversize = pos_ff >= POS_W'(MaxSectionBytes);
   assign advance  = accept && !oversize;

   always_comb begin
      pos_x = CMP_W'(pos_ff);
      len_x = CMP_W'(length_ff);
      // CRC word begins at length field - 1, or right after the header
      crc_start_x = (length_ff > 12'(mpat_pkg::LOOP_OFFSET)) ? len_x - CMP_W'(1)
                                                             : CMP_W'(mpat_pkg::HDR_BYTES);
      crc_ofs_x   = pos_x - crc_start_x;
      in_crc_word = (pos_x >= crc_start_x) && (crc_ofs_x < CMP_W'(mpat_pkg::CRC_BYTES));

      // fourth byte of an entry k: 4(k+1) <= length field - 9, i.e. pos + 2 <= length
      entry_hit = advance && !req_last_byte
                  && (pos_x >= CMP_W'(mpat_pkg::HDR_BYTES))
                  && (pos_x[1:0] == 2'b11)
                  && (pos_x < CMP_W'(ENTRY_END))
                  && (pos_x + CMP_W'(2) <= len_x);
   end

   always_comb begin
      crc_ctl.shift        = advance;
      crc_ctl.run          = pos_x >= CMP_W'(mpat_pkg::CRC_BYTES);
      crc_ctl.capture      = in_crc_word;
      crc_ctl.capture_done = in_crc_word && (crc_ofs_x[1:0] == 2'b11);
      crc_ctl.clear        = accept && req_last_byte;
   end

   mpat_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (crc_ctl),
      .data_byte (req_data_byte),
      .taps      (crc_taps),
      .crc_ok    (crc_ok)
   );

   // header capture, byte position, entry count
   always_comb begin
      pos_in      = pos_ff;
      length_in   = length_ff;
      cnt_in      = cnt_ff;
      tbl_id_in   = tbl_id_ff;
      syntax_in   = syntax_ff;
      tsid_in     = tsid_ff;
      version_in  = version_ff;
      cur_next_in = cur_next_ff;
      sec_num_in  = sec_num_ff;
      last_sec_in = last_sec_ff;

      if (advance) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_x < CMP_W'(mpat_pkg::HDR_BYTES)) begin
            case (pos_x[2:0])
               3'd0: tbl_id_in = req_data_byte;
               3'd1: begin
                  syntax_in       = req_data_byte[7];
                  length_in[11:8] = req_data_byte[3:0];
               end
               3'd2: length_in[7:0]  = req_data_byte;
               3'd3: tsid_in[15:8]   = req_data_byte;
               3'd4: tsid_in[7:0]    = req_data_byte;
               3'd5: begin
                  version_in  = req_data_byte[5:1];
                  cur_next_in = req_data_byte[0];
               end
               3'd6: sec_num_in  = req_data_byte;
               3'd7: last_sec_in = req_data_byte;
               default: ;
            endcase
         end
      end
      if (entry_hit) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // size and CRC verdict, judged on the state after this beat
   always_comb begin
      new_pos_x = CMP_W'(pos_in);
      size_bad  = oversize || (new_pos_x < CMP_W'(MinSectionBytes))
                  || (new_pos_x > CMP_W'(MaxSectionBytes));
      if (size_bad) begin
         status = mpat_pkg::STATUS_SIZE;
      end else if (!crc_ok) begin
         status = mpat_pkg::STATUS_CRC;
      end else begin
         status = mpat_pkg::STATUS_OK;
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = req_last_byte || entry_hit;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         pos_ff      <= '0;
         length_ff   <= '0;
         cnt_ff      <= '0;
         tbl_id_ff   <= '0;
         syntax_ff   <= 1'b0;
         tsid_ff     <= '0;
         version_ff  <= '0;
         cur_next_ff <= 1'b0;
         sec_num_ff  <= '0;
         last_sec_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         length_ff   <= length_in;
         cnt_ff      <= cnt_in;
         tbl_id_ff   <= tbl_id_in;
         syntax_ff   <= syntax_in;
         tsid_ff     <= tsid_in;
         version_ff  <= version_in;
         cur_next_ff <= cur_next_in;
         sec_num_ff  <= sec_num_in;
         last_sec_ff <= last_sec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         kind_ff       <= mpat_pkg::KIND_SUMMARY;
         prog_num_ff   <= '0;
         pid_ff        <= '0;
         o_tbl_id_ff   <= tbl_id_in;
         o_syntax_ff   <= syntax_in;
         o_tsid_ff     <= tsid_in;
         o_version_ff  <= version_in;
         o_cur_next_ff <= cur_next_in;
         o_sec_num_ff  <= sec_num_in;
         o_last_sec_ff <= last_sec_in;
         o_count_ff    <= size_bad ? '0 : mpat_pkg::COUNT_W'(cnt_ff);
         o_status_ff   <= status;
      end else if (entry_hit) begin
         // entry bytes: tap2 tap1 | tap0 data
         kind_ff       <= mpat_pkg::KIND_ENTRY;
         prog_num_ff   <= {crc_taps.tap2, crc_taps.tap1};
         pid_ff        <= {crc_taps.tap0[4:0], req_data_byte};
         o_tbl_id_ff   <= '0;
         o_syntax_ff   <= 1'b0;
         o_tsid_ff     <= '0;
         o_version_ff  <= '0;
         o_cur_next_ff <= 1'b0;
         o_sec_num_ff  <= '0;
         o_last_sec_ff <= '0;
         o_count_ff    <= '0;
         o_status_ff   <= mpat_pkg::STATUS_OK;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_prog_num         = prog_num_ff;
   assign rsp_pmt_pid          = pid_ff;
   assign rsp_tbl_id           = o_tbl_id_ff;
   assign rsp_syntax_indicator = o_syntax_ff;
   assign rsp_ts_id            = o_tsid_ff;
   assign rsp_version          = o_version_ff;
   assign rsp_current_next     = o_cur_next_ff;
   assign rsp_sect_num         = o_sec_num_ff;
   assign rsp_last_sect_num    = o_last_sec_ff;
   assign rsp_program_count    = o_count_ff;
   assign rsp_status           = o_status_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // last beat always leaves a summary in the output register
   a_last_gives_summary: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> rsp_valid_ff && (kind_ff == mpat_pkg::KIND_SUMMARY))
      else $error("last beat did not produce a summary");

   // sections with a size error (too short or too long) report no entries
   a_size_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == mpat_pkg::KIND_SUMMARY)
      && (o_status_ff == mpat_pkg::STATUS_SIZE) |-> (o_count_ff == '0))
      else $error("size error summary carries a program count");

   // byte position saturates at the section limit
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MaxSectionBytes))
      else $error("byte position ran past the section limit");

   // entry count stays within MaxPrograms
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MaxPrograms))
      else $error("entry count exceeded the program limit");

endmodule
